[hdl/fuzzy_substring_subsequence_scorer_defines.svh]
// assertion macros for the fuzzy scorer
`ifndef FUZZY_SUBSTRING_SUBSEQUENCE_SCORER_DEFINES_SVH
`define FUZZY_SUBSTRING_SUBSEQUENCE_SCORER_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define FSS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication checked outside reset
`define FSS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

[hdl/fss_pkg.sv]
// shared types and constants of the fuzzy scorer
package fss_pkg;
	localparam int QLEN_W = 6;
	localparam int SCORE_W = 14;
	localparam int PSCORE_W = 11;
	localparam int NREG = 5;
	localparam logic [2:0] REG_LEN = 3'd0;
	localparam logic [2:0] REG_Q0 = 3'd1;
	localparam logic [2:0] REG_Q1 = 3'd2;
	localparam logic [2:0] REG_Q2 = 3'd3;
	localparam logic [2:0] REG_Q3 = 3'd4;
	localparam logic [SCORE_W-1:0] SCORE_EXACT0 = 14'd10500;
	localparam logic [SCORE_W-1:0] SCORE_BASE = 14'd10000;
	localparam logic [SCORE_W-1:0] SCORE_BONUS = 14'd50;
	localparam logic [SCORE_W-1:0] SCORE_EMPTY = 14'd1;

	// beat passed from the front to the back
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} beat_t;
endpackage

[hdl/fss_front.sv]
// input stage: accepts target beats and pushes them into a two-entry queue
module fss_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [7:0]    target_byte,
	input  logic          target_end,
	output logic          q_valid,
	output fss_pkg::beat_t q_beat,
	input  logic          q_pop
);
	fss_pkg::beat_t mem_q [2];
	logic           wp_q, rp_q;
	logic [1:0]     cnt_q;
	logic           push;

	assign in_stall = (cnt_q == 2'd2);
	assign push = in_valid && !in_stall;
	assign q_valid = (cnt_q != 2'd0);
	assign q_beat = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q].data <= target_byte;
			mem_q[wp_q].last <= target_end;
		end
	end
endmodule

[hdl/fss_back.sv]
// match engine: window compare, subsequence scoring and result register
module fss_back #(
	parameter int QUERY_MAX  = 32,
	parameter int TARGET_MAX = 256
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	input  fss_pkg::beat_t              q_beat,
	output logic                        q_pop,
	input  logic [fss_pkg::QLEN_W-1:0]  qlen,
	input  logic [255:0]                qbytes,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        matched,
	output logic [fss_pkg::SCORE_W-1:0] score,
	output logic                        substring_hit
);
	localparam int PW = (TARGET_MAX > 2) ? $clog2(TARGET_MAX) : 2;
	localparam logic [PW-1:0] PMAX = PW'(TARGET_MAX - 1);

	logic [7:0]  win_q [32];
	logic [7:0]  win_n [32];
	logic [PW-1:0] pos_q;
	logic        found_q;
	logic [PW-1:0] start_q;
	logic [5:0]  cur_q, run_q;
	logic [fss_pkg::PSCORE_W-1:0] ps_q;
	logic        bonus_q;
	logic [5:0]  len;
	logic        eq, sub_new, do_step, last;
	logic [7:0]  cur_byte;
	logic        f_n, b_n;
	logic [PW-1:0] s_n;
	logic [5:0]  c_n, r_n;
	logic [fss_pkg::PSCORE_W-1:0] p_n;
	logic        m_r;
	logic [fss_pkg::SCORE_W-1:0] sc_r;
	logic        h_r;

	assign len = (qlen > 6'(QUERY_MAX)) ? 6'(QUERY_MAX) : qlen;
	assign do_step = q_valid && !(out_valid && out_stall);
	assign q_pop = do_step;
	assign last = q_beat.last;

	always_comb begin
		win_n[0] = q_beat.data;
		for (int k = 1; k < 32; k++) win_n[k] = win_q[k-1];
		eq = 1'b1;
		for (int k = 0; k < 32; k++) begin
			if (6'(k) < len && win_n[k] != qbytes[8*(5'(len - 6'd1 - 6'(k)))+:8])
				eq = 1'b0;
		end
		sub_new = (len != 6'd0) && !found_q &&
			(({1'b0, pos_q} + (PW+1)'(1)) >= (PW+1)'(len)) && eq;
		f_n = found_q || sub_new;
		s_n = sub_new ? PW'(({1'b0, pos_q} + (PW+1)'(1)) - (PW+1)'(len)) : start_q;
		cur_byte = qbytes[8*cur_q[4:0]+:8];
		c_n = cur_q; r_n = run_q; p_n = ps_q; b_n = bonus_q;
		if (cur_q < len) begin
			if (q_beat.data == cur_byte) begin
				p_n = ps_q + 11'd5 + 11'(run_q) * 11'd3;
				if ({1'b0, pos_q} < (PW+1)'(3) && cur_q == 6'd0) b_n = 1'b1;
				c_n = cur_q + 6'd1;
				r_n = run_q + 6'd1;
			end else begin
				r_n = 6'd0;
			end
		end
		m_r = 1'b0; sc_r = '0; h_r = 1'b0;
		if (len == 6'd0) begin
			m_r = 1'b1; sc_r = fss_pkg::SCORE_EMPTY;
		end else if (f_n) begin
			m_r = 1'b1; h_r = 1'b1;
			if (s_n == '0) sc_r = fss_pkg::SCORE_EXACT0;
			else if (32'(s_n) < 32'd10000) sc_r = fss_pkg::SCORE_BASE - 14'(s_n);
		end else if (c_n >= len) begin
			m_r = 1'b1;
			sc_r = 14'(p_n) + (b_n ? fss_pkg::SCORE_BONUS : 14'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 32; k++) win_q[k] <= 8'd0;
			pos_q <= '0; found_q <= 1'b0; start_q <= '0;
			cur_q <= '0; run_q <= '0; ps_q <= '0; bonus_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			// a new result may load in the cycle the old one leaves
			out_valid <= (do_step && last) || (out_valid && out_stall);
			if (do_step) begin
				if (last) begin
					for (int k = 0; k < 32; k++) win_q[k] <= 8'd0;
					pos_q <= '0; found_q <= 1'b0; start_q <= '0;
					cur_q <= '0; run_q <= '0; ps_q <= '0; bonus_q <= 1'b0;
				end else begin
					for (int k = 0; k < 32; k++) win_q[k] <= win_n[k];
					if (pos_q < PMAX) pos_q <= pos_q + PW'(1);
					found_q <= f_n; start_q <= s_n;
					cur_q <= c_n; run_q <= r_n; ps_q <= p_n; bonus_q <= b_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_step && last) begin
			matched <= m_r;
			score <= sc_r;
			substring_hit <= h_r;
		end
	end
endmodule

[hdl/fss_regs.sv]
// configuration registers behind the apb port
module fss_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [5:0]                 paddr,
	input  logic [63:0]                pwdata,
	output logic [63:0]                prdata,
	output logic                       pready,
	output logic [fss_pkg::QLEN_W-1:0] qlen,
	output logic [255:0]               qbytes
);
	logic [5:0]  len_q;
	logic [63:0] qb_q [4];
	logic [2:0]  idx;
	logic        wr;

	assign pready = 1'b1;
	assign idx = paddr[5:3];
	assign wr = psel && penable && pwrite;
	assign qlen = len_q;
	assign qbytes = {qb_q[3], qb_q[2], qb_q[1], qb_q[0]};

	always_comb begin
		case (idx)
			fss_pkg::REG_LEN: prdata = {58'd0, len_q};
			fss_pkg::REG_Q0: prdata = qb_q[0];
			fss_pkg::REG_Q1: prdata = qb_q[1];
			fss_pkg::REG_Q2: prdata = qb_q[2];
			fss_pkg::REG_Q3: prdata = qb_q[3];
			default: prdata = 64'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			for (int k = 0; k < 4; k++) qb_q[k] <= '0;
		end else if (wr) begin
			if (idx == fss_pkg::REG_LEN) len_q <= pwdata[5:0];
			else if (idx < 3'(fss_pkg::NREG)) qb_q[2'(idx - fss_pkg::REG_Q0)] <= pwdata;
		end
	end
endmodule

[hdl/fuzzy_substring_subsequence_scorer.sv]
// top level of the fuzzy substring / subsequence scorer
// channel  dir  handshake           payload
// in       in   in_valid/in_stall   target_byte, target_end
// out      out  out_valid/out_stall matched, score, substring_hit
// cfg      in   apb psel/penable    paddr, pwdata, prdata
// one target beat per cycle unless in_stall; the back engine steps once per beat
// a final beat goes through the queue, then the result register sets out_valid
// reset clears string state, queue pointers and config at once, no sweep
// out_stall holds the result register; the two-entry queue absorbs input
`include "fuzzy_substring_subsequence_scorer_defines.svh"
module fuzzy_substring_subsequence_scorer #(
	parameter int QUERY_MAX  = 32,
	parameter int TARGET_MAX = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  target_byte,
	input  logic        target_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        matched,
	output logic [13:0] score,
	output logic        substring_hit,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);
	logic           q_valid, q_pop;
	fss_pkg::beat_t q_beat;
	logic [5:0]     qlen;
	logic [255:0]   qbytes;

	fss_regs u_regs (.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .qlen, .qbytes);
	fss_front u_front (.clk, .arst_n, .in_valid, .in_stall, .target_byte,
		.target_end, .q_valid, .q_beat, .q_pop);
	fss_back #(.QUERY_MAX(QUERY_MAX), .TARGET_MAX(TARGET_MAX)) u_back (
		.clk, .arst_n, .q_valid, .q_beat, .q_pop, .qlen, .qbytes,
		.out_valid, .out_stall, .matched, .score, .substring_hit);

	`FSS_ASSERT_IMP(a_no_pop_empty, q_pop, q_valid, "pop from empty queue")
	`FSS_ASSERT_IMP(a_hit_matched, out_valid && substring_hit, matched, "hit without match")
	`FSS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(score),
		"stalled result changed")
endmodule

[verif/fuzzy_substring_subsequence_scorer_test.sv]
// self-checking testbench for the fuzzy substring / subsequence scorer
module fuzzy_substring_subsequence_scorer_test;
	typedef struct packed {
		logic        matched;
		logic [13:0] score;
		logic        substring_hit;
	} verdict_t;

	class match_scoreboard;
		// query settings as seen by the block
		bit [5:0]  qlen;
		bit [63:0] qwords [4];
		// per-string state
		bit [7:0]  window [32];
		int        pos;
		bit        found;
		int        found_at;
		int        cursor;
		int        run;
		bit [10:0] partial;
		bit        bonus;
		verdict_t  pending [$];
		int        errors;

		function void clear_string();
			foreach (window[i]) window[i] = 8'h00;
			pos = 0; found = 0; found_at = 0; cursor = 0; run = 0;
			partial = '0; bonus = 0;
		endfunction

		function void reset_all();
			qlen = '0;
			foreach (qwords[i]) qwords[i] = '0;
			clear_string();
			pending.delete();
			errors = 0;
		endfunction

		function bit [7:0] qbyte(int i);
			i = i & 31;
			return qwords[i >> 3][8*(i & 7) +: 8];
		endfunction

		function void note_target(bit [7:0] b, bit last);
			int len;
			int idx;
			bit eq;
			verdict_t v;
			len = (qlen > 32) ? 32 : qlen;
			idx = pos;
			for (int i = 31; i > 0; i--) window[i] = window[i-1];
			window[0] = b;
			if (len > 0 && !found && idx + 1 >= len) begin
				eq = 1;
				for (int k = 0; k < len; k++)
					if (window[k] != qbyte(len - 1 - k)) eq = 0;
				if (eq) begin
					found = 1;
					found_at = idx + 1 - len;
				end
			end
			if (cursor < len) begin
				if (b == qbyte(cursor)) begin
					partial = partial + 11'(5 + 3 * run);
					if (idx < 3 && cursor == 0) bonus = 1;
					cursor++;
					run = (run + 1) & 63;
				end else begin
					run = 0;
				end
			end
			if (pos < 255) pos++;
			if (!last) return;
			v = '0;
			if (len == 0) begin
				v.matched = 1; v.score = 14'd1;
			end else if (found) begin
				v.matched = 1; v.substring_hit = 1;
				v.score = (found_at == 0) ? 14'd10500 : 14'(10000 - found_at);
			end else if (cursor >= len) begin
				v.matched = 1;
				v.score = 14'(partial) + (bonus ? 14'd50 : 14'd0);
			end
			pending = {pending, v};
			clear_string();
		endfunction

		function void check_result(verdict_t got);
			verdict_t exp;
			if (pending.size() == 0) begin
				$error("unexpected result matched=%0d score=%0d hit=%0d",
					got.matched, got.score, got.substring_hit);
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (got.matched !== exp.matched) begin
				$error("matched: expected %0d got %0d", exp.matched, got.matched);
				errors++;
			end
			if (got.score !== exp.score) begin
				$error("score: expected %0d got %0d", exp.score, got.score);
				errors++;
			end
			if (got.substring_hit !== exp.substring_hit) begin
				$error("substring_hit: expected %0d got %0d",
					exp.substring_hit, got.substring_hit);
				errors++;
			end
		endfunction
	endclass

	localparam int LIMIT = 400000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [7:0]  target_byte = 0;
	logic        target_end = 0;
	logic        out_valid;
	logic        out_stall = 0;
	logic        matched;
	logic [13:0] score;
	logic        substring_hit;
	logic        psel = 0;
	logic        penable = 0;
	logic        pwrite = 0;
	logic [5:0]  paddr = 0;
	logic [63:0] pwdata = 0;
	logic [63:0] prdata;
	logic        pready;

	match_scoreboard sb;
	int  send_idle_pct;
	int  recv_idle_pct;
	int  hold_off;
	int  cycles;
	bit  timed_out;
	bit [7:0] alphabet [4];

	fuzzy_substring_subsequence_scorer u_dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT && !timed_out) begin
			timed_out = 1;
			$display("FAIL fuzzy_substring_subsequence_scorer");
			$finish;
		end
	end

	// receiver: random stall plus commanded long hold-off
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result('{matched, score, substring_hit});
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_stall <= 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= {idx, 3'b000}; pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		if (idx == fss_pkg::REG_LEN) sb.qlen = val[5:0];
		else sb.qwords[idx - fss_pkg::REG_Q0] = val;
		@(posedge clk);
	endtask

	task automatic send_byte(logic [7:0] b, logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1; target_byte <= b; target_end <= last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_target(b, last);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_byte();
		return ($urandom_range(9) == 0) ? 8'($urandom) : alphabet[$urandom_range(3)];
	endfunction

	// sets a query of given length from the small alphabet (or fully random)
	task automatic set_query(int len, bit wild);
		logic [63:0] w;
		for (int r = 0; r < 4; r++) begin
			for (int j = 0; j < 8; j++)
				w[8*j +: 8] = wild ? 8'($urandom) : alphabet[$urandom_range(3)];
			write_reg(fss_pkg::REG_Q0 + 3'(r), w);
		end
		write_reg(fss_pkg::REG_LEN, 64'(len));
	endtask

	// target with a planted copy, a scattered subsequence of the query, or random bytes only
	task automatic send_string(int tlen);
		int len;
		int mode;
		int at;
		int qi;
		logic [7:0] b;
		len = (sb.qlen > 32) ? 32 : sb.qlen;
		mode = $urandom_range(3);
		at = (tlen > len) ? $urandom_range(tlen - len) : 0;
		qi = 0;
		for (int i = 0; i < tlen; i++) begin
			b = pick_byte();
			if (mode == 0 && i >= at && i - at < len) b = sb.qbyte(i - at);
			else if (mode == 1 && qi < len && $urandom_range(2) != 0) begin
				b = sb.qbyte(qi); qi++;
			end
			send_byte(b, i == tlen - 1);
		end
	endtask

	task automatic run_phase(int strings);
		int qlens[] = '{1, 2, 3, 5, 8};
		for (int s = 0; s < strings; s++) begin
			if (s % 6 == 0) begin
				drain();
				set_query($urandom_range(7) == 0 ? $urandom_range(63) :
					qlens[$urandom_range(4)], $urandom_range(9) == 0);
			end
			send_string($urandom_range(39) == 0 ? $urandom_range(40, 300) :
				$urandom_range(1, 12));
		end
	endtask

	initial begin
		sb = new();
		sb.reset_all();
		alphabet = '{8'h61, 8'h62, 8'h00, 8'hff};
		send_idle_pct = 0; recv_idle_pct = 0; hold_off = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty query, substring at 0, later, subsequence with bonus, miss
		send_byte(8'h61, 1);
		drain();
		write_reg(fss_pkg::REG_Q0, 64'h0000_0000_0000_6261);
		write_reg(fss_pkg::REG_LEN, 64'd2);
		send_byte(8'h61, 0); send_byte(8'h62, 1);
		send_byte(8'h00, 0); send_byte(8'h61, 0); send_byte(8'h62, 1);
		send_byte(8'h61, 0); send_byte(8'hff, 0); send_byte(8'h62, 1);
		send_byte(8'hff, 0); send_byte(8'h00, 1);
		drain();
		write_reg(fss_pkg::REG_Q0, 64'hffff_ffff_ffff_ffff);
		write_reg(fss_pkg::REG_Q0 + 3'd1, 64'hffff_ffff_ffff_ffff);
		write_reg(fss_pkg::REG_Q0 + 3'd2, 64'hffff_ffff_ffff_ffff);
		write_reg(fss_pkg::REG_Q0 + 3'd3, 64'hffff_ffff_ffff_ffff);
		write_reg(fss_pkg::REG_LEN, 64'd63);
		for (int i = 0; i < 33; i++) send_byte(8'hff, i == 32);
		// long target drives the position counter to saturation
		drain();
		write_reg(fss_pkg::REG_LEN, 64'd32);
		for (int i = 0; i < 300; i++) send_byte(i < 290 ? 8'h00 : 8'hff, i == 299);
		drain();

		send_idle_pct = 27; recv_idle_pct = 47;
		run_phase(18);
		// long receiver hold-off so the block backs up
		hold_off = 200;
		run_phase(6);
		drain();
		send_idle_pct = 47; recv_idle_pct = 27;
		run_phase(18);
		send_idle_pct = 0; recv_idle_pct = 0;
		run_phase(18);
		drain();
		write_reg(fss_pkg::REG_LEN, 64'd0);
		write_reg(fss_pkg::REG_Q0, 64'd0);
		send_byte(8'h00, 1);
		drain();

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("PASS fuzzy_substring_subsequence_scorer");
		else
			$display("FAIL fuzzy_substring_subsequence_scorer");
		$finish;
	end
endmodule
